// ===== hdl/stko_pkg.sv =====
// Shared widths, constants, controller/datapath bundles and a helper function.
`timescale 1ns / 1ps
package stko_pkg;

	localparam int PRICE_W = 24;
	localparam int LEVEL_W = 14;
	localparam int QUO_W   = 14;
	localparam int PROD_W  = PRICE_W + LEVEL_W;
	localparam int STEP_W  = 4;
	localparam int SUM_W   = 16;
	localparam int RECIP_W = 32;

	localparam logic [LEVEL_W-1:0] RSV_FULL      = 14'd10000;
	localparam logic [LEVEL_W-1:0] RSV_FLAT      = 14'd5000;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 14'd10000;
	localparam logic [LEVEL_W-1:0] LEVEL_RESET   = 14'd5000;
	localparam logic [SUM_W-1:0]   DIV3_RECIP    = 16'd43691;
	localparam int                 DIV3_SHIFT    = 17;

	typedef struct packed {
		logic start;
		logic scan_step;
		logic prep;
		logic mul;
		logic div_step;
		logic k_step;
		logic d_step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic div_last;
	} status_t;

	// Exact floor(x / 3) for any x up to 49151 (a 14-bit result), by reciprocal multiplication.
	function automatic logic [LEVEL_W-1:0] div3(input logic [SUM_W-1:0] x);
		logic [RECIP_W-1:0] p;
		p = RECIP_W'(x) * RECIP_W'(DIV3_RECIP);
		return p[DIV3_SHIFT+LEVEL_W-1:DIV3_SHIFT];
	endfunction

endpackage

// ===== hdl/stko_bar_if.sv =====
// Input channel carrying one daily price bar per transaction.
`timescale 1ns / 1ps
interface stko_bar_if;
	logic                         valid;
	logic                         ready;
	logic [stko_pkg::PRICE_W-1:0] high_price;
	logic [stko_pkg::PRICE_W-1:0] low_price;
	logic [stko_pkg::PRICE_W-1:0] close_price;

	modport source (output valid, output high_price, output low_price, output close_price,
		input ready);
	modport sink (input valid, input high_price, input low_price, input close_price,
		output ready);
endinterface

// ===== hdl/stko_res_if.sv =====
// Output channel carrying the RSV, K and D values of one bar per transaction.
`timescale 1ns / 1ps
interface stko_res_if;
	logic                         valid;
	logic                         ready;
	logic [stko_pkg::LEVEL_W-1:0] rsv_value;
	logic [stko_pkg::LEVEL_W-1:0] k_value;
	logic [stko_pkg::LEVEL_W-1:0] d_value;

	modport source (output valid, output rsv_value, output k_value, output d_value,
		input ready);
	modport sink (input valid, input rsv_value, input k_value, input d_value,
		output ready);
endinterface

// ===== hdl/stko_cfg_if.sv =====
// Configuration write channel carrying the initial K/D level.
`timescale 1ns / 1ps
interface stko_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [stko_pkg::LEVEL_W-1:0] initial_level;

	modport source (output valid, output initial_level, input ready);
	modport sink (input valid, input initial_level, output ready);
endinterface

// ===== hdl/stko_datapath.sv =====
// Datapath: price window, range scan, RSV divider, K/D smoothing and output registers.
`timescale 1ns / 1ps
module stko_datapath #(
	parameter int WINDOW_DAYS = 9
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [stko_pkg::LEVEL_W-1:0] cfg_level,
	input  logic [stko_pkg::PRICE_W-1:0] high_price,
	input  logic [stko_pkg::PRICE_W-1:0] low_price,
	input  logic [stko_pkg::PRICE_W-1:0] close_price,
	input  stko_pkg::cmd_t               cmd,
	output stko_pkg::status_t            status,
	output logic [stko_pkg::LEVEL_W-1:0] rsv_value,
	output logic [stko_pkg::LEVEL_W-1:0] k_value,
	output logic [stko_pkg::LEVEL_W-1:0] d_value
);

	localparam int CW = $clog2(WINDOW_DAYS + 1);
	localparam int IW = $clog2(WINDOW_DAYS);

	logic [stko_pkg::PRICE_W-1:0] high_win_q [WINDOW_DAYS];
	logic [stko_pkg::PRICE_W-1:0] low_win_q  [WINDOW_DAYS];
	logic [CW-1:0]                bars_q;
	logic [CW-1:0]                idx_q;
	logic                         first_q;
	logic [stko_pkg::LEVEL_W-1:0] init_level_q;

	logic [stko_pkg::PRICE_W-1:0] close_q;
	logic [stko_pkg::PRICE_W-1:0] top_q;
	logic [stko_pkg::PRICE_W-1:0] bot_q;
	logic [stko_pkg::PRICE_W-1:0] num_q;
	logic [stko_pkg::PRICE_W-1:0] den_q;
	logic                         flat_q;
	logic [stko_pkg::PROD_W-1:0]  rem_q;
	logic [stko_pkg::PROD_W-1:0]  dsh_q;
	logic [stko_pkg::QUO_W-1:0]   quo_q;
	logic [stko_pkg::STEP_W-1:0]  step_q;
	logic [stko_pkg::LEVEL_W-1:0] rsv_q;
	logic [stko_pkg::LEVEL_W-1:0] k_q;
	logic [stko_pkg::LEVEL_W-1:0] k_lvl_q;
	logic [stko_pkg::LEVEL_W-1:0] d_lvl_q;
	logic [stko_pkg::LEVEL_W-1:0] rsv_out_q;
	logic [stko_pkg::LEVEL_W-1:0] k_out_q;
	logic [stko_pkg::LEVEL_W-1:0] d_out_q;

	logic [stko_pkg::PRICE_W-1:0] scan_high;
	logic [stko_pkg::PRICE_W-1:0] scan_low;
	logic [stko_pkg::PRICE_W-1:0] close_clamped;
	logic                         rem_ge;
	logic [stko_pkg::LEVEL_W-1:0] rsv_now;
	logic [stko_pkg::LEVEL_W-1:0] level_cap;
	logic [stko_pkg::LEVEL_W-1:0] d_next;

	assign scan_high = high_win_q[idx_q[IW-1:0]];
	assign scan_low  = low_win_q[idx_q[IW-1:0]];

	always_comb begin
		if (close_q < bot_q) begin
			close_clamped = bot_q;
		end else if (close_q > top_q) begin
			close_clamped = top_q;
		end else begin
			close_clamped = close_q;
		end
	end

	assign rem_ge    = (rem_q >= dsh_q);
	assign rsv_now   = flat_q ? stko_pkg::RSV_FLAT : quo_q;
	assign level_cap = (init_level_q > stko_pkg::LEVEL_MAX) ? stko_pkg::LEVEL_MAX : init_level_q;
	assign d_next    = first_q ? k_q :
		stko_pkg::div3(stko_pkg::SUM_W'({d_lvl_q, 1'b0}) + stko_pkg::SUM_W'(k_q));

	assign status.scan_done = (idx_q == bars_q);
	assign status.div_last  = (step_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bars_q       <= '0;
			first_q      <= 1'b0;
			init_level_q <= stko_pkg::LEVEL_RESET;
		end else begin
			if (cfg_we) begin
				init_level_q <= cfg_level;
			end
			if (cmd.start) begin
				first_q <= (bars_q == '0);
				if (bars_q != CW'(WINDOW_DAYS)) begin
					bars_q <= bars_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			high_win_q[0] <= high_price;
			low_win_q[0]  <= low_price;
			for (int i = 1; i < WINDOW_DAYS; i++) begin
				high_win_q[i] <= high_win_q[i-1];
				low_win_q[i]  <= low_win_q[i-1];
			end
			close_q <= close_price;
			top_q   <= high_price;
			bot_q   <= low_price;
			idx_q   <= CW'(1);
		end
		if (cmd.scan_step) begin
			if (scan_high > top_q) begin
				top_q <= scan_high;
			end
			if (scan_low < bot_q) begin
				bot_q <= scan_low;
			end
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.prep) begin
			num_q  <= close_clamped - bot_q;
			den_q  <= top_q - bot_q;
			flat_q <= (top_q <= bot_q);
		end
		if (cmd.mul) begin
			rem_q  <= stko_pkg::PROD_W'(num_q) * stko_pkg::PROD_W'(stko_pkg::RSV_FULL);
			dsh_q  <= stko_pkg::PROD_W'(den_q) << (stko_pkg::QUO_W - 1);
			quo_q  <= '0;
			step_q <= stko_pkg::STEP_W'(stko_pkg::QUO_W - 1);
		end
		if (cmd.div_step) begin
			if (rem_ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q  <= {quo_q[stko_pkg::QUO_W-2:0], rem_ge};
			dsh_q  <= dsh_q >> 1;
			step_q <= step_q - 1'b1;
		end
		if (cmd.k_step) begin
			rsv_q <= rsv_now;
			k_q   <= first_q ? level_cap :
				stko_pkg::div3(stko_pkg::SUM_W'({k_lvl_q, 1'b0}) + stko_pkg::SUM_W'(rsv_now));
		end
		if (cmd.d_step) begin
			k_lvl_q <= k_q;
			d_lvl_q <= d_next;
		end
		if (cmd.load_out) begin
			rsv_out_q <= rsv_q;
			k_out_q   <= k_lvl_q;
			d_out_q   <= d_lvl_q;
		end
	end

	assign rsv_value = rsv_out_q;
	assign k_value   = k_out_q;
	assign d_value   = d_out_q;

endmodule

// ===== hdl/stko_ctrl.sv =====
// Controller: sequences one bar through scan, divide and smoothing and owns the handshakes.
`timescale 1ns / 1ps
module stko_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  stko_pkg::status_t status,
	output stko_pkg::cmd_t    cmd
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_SCAN  = 8'b0000_0010,
		S_PREP  = 8'b0000_0100,
		S_MUL   = 8'b0000_1000,
		S_DIV   = 8'b0001_0000,
		S_KSTEP = 8'b0010_0000,
		S_DSTEP = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				if (status.scan_done) begin
					state_d = S_PREP;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = S_KSTEP;
				end
			end
			S_KSTEP: begin
				cmd.k_step = 1'b1;
				state_d    = S_DSTEP;
			end
			S_DSTEP: begin
				cmd.d_step = 1'b1;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// An accepted bar always starts the window scan.
	a_start_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_SCAN))
		else $error("accepted bar did not start the scan");

	// A finished result never overwrites one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before its transaction");

	// A result only appears after the final sequencing step.
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result became valid outside the done state");

	// The divider always runs to completion before smoothing.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_KSTEP) |-> ($past(state_q) == S_DIV && $past(status.div_last)))
		else $error("smoothing started before the divider finished");

endmodule

// ===== hdl/stochastic_kd_oscillator_core.sv =====
// Each bar passes through the scan, prep, multiply, divide, K, D and done states in that order.
// A new bar is accepted only after the previous bar's result has been loaded into the output register.
// The range scan reads one window entry a cycle; the RSV divider retires one quotient bit a cycle.
// A result waits in the output register while the next bar is accepted.
// Reset empties the window, sets the initial level register to 5000 and drops any pending result.
`timescale 1ns / 1ps
module stochastic_kd_oscillator_core #(
	parameter int WINDOW_DAYS = 9
) (
	input  logic       clk,
	input  logic       arst_n,
	stko_bar_if.sink   bar,
	stko_res_if.source result,
	stko_cfg_if.sink   cfg
);

	stko_pkg::cmd_t    cmd;
	stko_pkg::status_t status;

	assign cfg.ready = 1'b1;

	stko_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (bar.valid),
		.in_ready  (bar.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	stko_datapath #(
		.WINDOW_DAYS (WINDOW_DAYS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg.valid),
		.cfg_level   (cfg.initial_level),
		.high_price  (bar.high_price),
		.low_price   (bar.low_price),
		.close_price (bar.close_price),
		.cmd         (cmd),
		.status      (status),
		.rsv_value   (result.rsv_value),
		.k_value     (result.k_value),
		.d_value     (result.d_value)
	);

endmodule
